// File: src/esa_pkg.sv
// ----------------------------------------------------------------------------
// esa_pkg
// Shared types, codes and default sizes for the entity slot allocator.
// ----------------------------------------------------------------------------
package esa_pkg;

	// default sizes of the slot table
	localparam int CAPACITY_DEF            = 64;
	localparam int NUM_COMPONENT_KINDS_DEF = 16;
	localparam int IDENT_WIDTH_DEF         = 32;

	// fixed field widths on the stream ports
	localparam int OP_W        = 3;
	localparam int SLOT_FW     = 6;
	localparam int KIND_FW     = 4;
	localparam int IDENT_FW    = 32;
	localparam int STATUS_W    = 2;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 48;

	// request codes
	typedef enum logic [OP_W-1:0] {
		OP_NEW    = 3'd0,
		OP_DELETE = 3'd1,
		OP_ADD    = 3'd2,
		OP_REMOVE = 3'd3,
		OP_QUERY  = 3'd4
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_USED  = 2'd2,
		STAT_COMPONENT = 2'd3
	} status_t;

	// request sequencer states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

endpackage

// File: src/entity_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// entity_slot_allocator_top
// Entity slot table with identifier handout and component presence bits.
//
//   channel   | direction | fields (tdata, lowest bit up)
//   ----------+-----------+---------------------------------------------------
//   s_axis    | in        | op[2:0], slot_index[8:3], component_kind[12:9]
//   m_axis    | out       | slot_out[5:0], entity_ident[37:6], present[38],
//             |           | status[40:39]
//
// Each request has a transfer cycle, which reads the identifier and presence
// RAMs and encodes the lowest free slot, and an update cycle, which does the
// read-modify-write of both RAMs, the used bitmap and the identifier counter.
// Reset clears the used bitmap and sets the counter to one at once; the RAMs
// need no clearing since a slot's entries are written when it is allocated.
// A result waits in the output register; a following request is taken and
// held in its update cycle until that register is free.
// ----------------------------------------------------------------------------
module entity_slot_allocator_top #(
	parameter int CAPACITY            = esa_pkg::CAPACITY_DEF,
	parameter int NUM_COMPONENT_KINDS = esa_pkg::NUM_COMPONENT_KINDS_DEF,
	parameter int IDENT_WIDTH         = esa_pkg::IDENT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// op, slot_index, component_kind
	input  logic [esa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// slot_out, entity_ident, present, status
	output logic [esa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	import esa_pkg::*;

	localparam int SW = $clog2(CAPACITY);
	localparam int KW = (NUM_COMPONENT_KINDS > 1) ? $clog2(NUM_COMPONENT_KINDS) : 1;
	localparam int NK = NUM_COMPONENT_KINDS;

	// state registers
	state_t                 state_q, state_d;
	logic [CAPACITY-1:0]    used_q;
	logic [IDENT_WIDTH-1:0] counter_q;

	// request held for the update cycle
	op_t                    op_s1;
	logic [SLOT_FW-1:0]     slot_s1;
	logic [KIND_FW-1:0]     kind_s1;
	logic                   free_found_s1;
	logic [SW-1:0]          free_idx_s1;

	// output register
	logic                   out_valid_q;
	logic [SLOT_FW-1:0]     slot_out_q;
	logic [IDENT_FW-1:0]    ident_out_q;
	logic                   present_q;
	status_t                status_q;

	// handshake and decode
	logic                   in_xfer;
	logic                   exec_fire;
	logic [SLOT_FW-1:0]     in_slot;
	logic [SW+SLOT_FW-1:0]  in_slot_ext;
	logic [SW-1:0]          rd_addr;
	logic                   free_found;
	logic [SW-1:0]          free_idx;

	// memory ports
	logic                   ident_we, pres_we;
	logic [SW-1:0]          wr_addr;
	logic [IDENT_WIDTH-1:0] ident_wdata, ident_rdata;
	logic [NK-1:0]          pres_wdata, pres_rdata;

	// update-cycle signals
	logic [SW+SLOT_FW-1:0]  slot_ext;
	logic [SW-1:0]          slot_addr;
	logic                   slot_ok;
	logic [KW+KIND_FW-1:0]  kind_ext;
	logic [KW-1:0]          kind_idx;
	logic                   kind_ok;
	logic [NK-1:0]          kind_mask;
	logic                   kind_bit;
	logic [SW+SLOT_FW-1:0]  free_ext;
	logic [IDENT_WIDTH+IDENT_FW-1:0] ident_rd_ext, counter_ext;
	logic                   set_used, clr_used, bump_counter;
	logic [SLOT_FW-1:0]     res_slot;
	logic [IDENT_FW-1:0]    res_ident;
	logic                   res_present;
	status_t                res_status;

	// input decode and memory read address
	assign in_slot     = s_axis_tdata[OP_W +: SLOT_FW];
	assign in_slot_ext = {{SW{1'b0}}, in_slot};
	assign rd_addr     = in_slot_ext[SW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		s_axis_tready = 1'b0;
		exec_fire     = 1'b0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_EXEC: exec_fire     = !out_valid_q || m_axis_tready;
			default: s_axis_tready = 1'b0;
		endcase
	end

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// lowest free slot
	esa_free_find #(
		.CAPACITY (CAPACITY)
	) u_free_find (
		.used  (used_q),
		.found (free_found),
		.index (free_idx)
	);

	// capture the request on its transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1         <= op_t'(s_axis_tdata[OP_W-1:0]);
			slot_s1       <= in_slot;
			kind_s1       <= s_axis_tdata[OP_W+SLOT_FW +: KIND_FW];
			free_found_s1 <= free_found;
			free_idx_s1   <= free_idx;
		end
	end

	// identifier and presence memories
	esa_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (IDENT_WIDTH)
	) u_ident_ram (
		.clk   (clk),
		.we    (ident_we),
		.waddr (wr_addr),
		.wdata (ident_wdata),
		.re    (in_xfer),
		.raddr (rd_addr),
		.rdata (ident_rdata)
	);

	esa_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (NK)
	) u_pres_ram (
		.clk   (clk),
		.we    (pres_we),
		.waddr (wr_addr),
		.wdata (pres_wdata),
		.re    (in_xfer),
		.raddr (rd_addr),
		.rdata (pres_rdata)
	);

	// slot and kind range checks
	assign slot_ext     = {{SW{1'b0}}, slot_s1};
	assign slot_addr    = slot_ext[SW-1:0];
	assign slot_ok      = (slot_ext < (SW+SLOT_FW)'(CAPACITY)) && used_q[slot_addr];
	assign kind_ext     = {{KW{1'b0}}, kind_s1};
	assign kind_idx     = kind_ext[KW-1:0];
	assign kind_ok      = kind_ext < (KW+KIND_FW)'(NUM_COMPONENT_KINDS);
	assign kind_mask    = NK'(1) << kind_idx;
	assign kind_bit     = kind_ok && ((pres_rdata & kind_mask) != '0);
	assign free_ext     = {{SLOT_FW{1'b0}}, free_idx_s1};
	assign ident_rd_ext = {{IDENT_FW{1'b0}}, ident_rdata};
	assign counter_ext  = {{IDENT_FW{1'b0}}, counter_q};

	// read-modify-write of the slot entry
	always_comb begin
		ident_we     = 1'b0;
		pres_we      = 1'b0;
		wr_addr      = slot_addr;
		ident_wdata  = '0;
		pres_wdata   = '0;
		set_used     = 1'b0;
		clr_used     = 1'b0;
		bump_counter = 1'b0;
		res_slot     = slot_s1;
		res_ident    = '0;
		res_present  = 1'b0;
		res_status   = STAT_OK;
		case (op_s1)
			OP_NEW: begin
				res_slot = '0;
				if (free_found_s1) begin
					wr_addr      = free_idx_s1;
					ident_we     = exec_fire;
					pres_we      = exec_fire;
					ident_wdata  = counter_q;
					set_used     = exec_fire;
					bump_counter = exec_fire;
					res_slot     = free_ext[SLOT_FW-1:0];
					res_ident    = counter_ext[IDENT_FW-1:0];
				end else begin
					res_status = STAT_FULL;
				end
			end
			OP_DELETE, OP_ADD, OP_REMOVE, OP_QUERY: begin
				if (!slot_ok) begin
					res_status = STAT_NOT_USED;
				end else begin
					res_ident = ident_rd_ext[IDENT_FW-1:0];
					case (op_s1)
						OP_DELETE: begin
							ident_we = exec_fire;
							pres_we  = exec_fire;
							clr_used = exec_fire;
						end
						OP_ADD: begin
							if (!kind_ok || kind_bit) begin
								res_status = STAT_COMPONENT;
							end else begin
								pres_we    = exec_fire;
								pres_wdata = pres_rdata | kind_mask;
							end
						end
						OP_REMOVE: begin
							if (!kind_bit) begin
								res_status = STAT_COMPONENT;
							end else begin
								pres_we    = exec_fire;
								pres_wdata = pres_rdata & ~kind_mask;
							end
						end
						default: res_present = kind_bit;
					endcase
				end
			end
			default: res_status = STAT_OK;
		endcase
	end

	// used bitmap and identifier counter, counter skips zero on wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			counter_q <= IDENT_WIDTH'(1);
		end else begin
			if (set_used) used_q[free_idx_s1] <= 1'b1;
			if (clr_used) used_q[slot_addr]   <= 1'b0;
			if (bump_counter) begin
				if (&counter_q) counter_q <= IDENT_WIDTH'(1);
				else            counter_q <= counter_q + 1'b1;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (exec_fire) begin
			slot_out_q  <= res_slot;
			ident_out_q <= res_ident;
			present_q   <= res_present;
			status_q    <= res_status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, status_q, present_q, ident_out_q, slot_out_q};

endmodule

// File: src/esa_ram.sv
// ----------------------------------------------------------------------------
// esa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module esa_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, data held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/esa_free_find.sv
// ----------------------------------------------------------------------------
// esa_free_find
// Priority encoder that finds the lowest free slot in the used bitmap.
// ----------------------------------------------------------------------------
module esa_free_find #(
	parameter int CAPACITY = 64
) (
	input  logic [CAPACITY-1:0]         used,
	output logic                        found,
	output logic [$clog2(CAPACITY)-1:0] index
);

	// lowest zero wins: scan downward so the last hit is the lowest one
	always_comb begin
		found = 1'b0;
		index = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!used[i]) begin
				found = 1'b1;
				index = ($clog2(CAPACITY))'(i);
			end
		end
	end

endmodule
